// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the cipher RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define KBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the following cycle.
`define KBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KBC_ASSERT(label, clk, rst_n, prop, msg)
`define KBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/kbc_pkg.sv
// Package for the keyed byte add/sub cipher.
// Types, register indexes and byte arithmetic constants; no dependencies.
`default_nettype none

package kbc_pkg;

	// Sizing defaults and fixed register file size
	localparam int NUM_KEYS_DEF = 4;
	localparam int KEY_BITS_DEF = 32;
	localparam int KEY_REGS     = 4;
	localparam int SLOT_W       = 2;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = 3;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MODE_DECRYPT = 3'd0,
		REG_KEY_COUNT    = 3'd1,
		REG_KEY_ZERO     = 3'd2,
		REG_KEY_ONE      = 3'd3,
		REG_KEY_TWO      = 3'd4,
		REG_KEY_THREE    = 3'd5
	} kbc_reg_idx_t;

	// Special byte codes
	localparam logic [7:0] BYTE_MAX     = 8'h7F;  // +127
	localparam logic [7:0] BYTE_NEG_MAX = 8'h81;  // -127
	localparam logic [7:0] BYTE_MIN     = 8'h80;  // -128

	// Wrap limits in the 10-bit working width
	localparam logic signed [9:0] W_POS_LIM = 10'sd127;
	localparam logic signed [9:0] W_NEG_LIM = -10'sd127;
	localparam logic signed [9:0] W_WRAP    = 10'sd254;

	// Configuration register contents
	typedef struct packed {
		logic                          mode_decrypt;
		logic [CNT_W-1:0]              key_count;
		logic [KEY_REGS-1:0][7:0]      keys;
	} kbc_cfg_t;

	// Per-byte step selection
	typedef struct packed {
		logic [7:0] key;
		logic       add_step;
		logic       decrypt;
	} kbc_step_t;

endpackage

`default_nettype wire

// File: hw/rtl/kbc_cfg_regs.sv
// Configuration register file of the cipher.
// Depends on kbc_pkg for the register indexes and the config struct.
`default_nettype none

module kbc_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [kbc_pkg::IDX_W-1:0]  wr_index,
	input  wire logic [7:0]                 wr_data,
	output kbc_pkg::kbc_cfg_t               cfg
);

	kbc_pkg::kbc_cfg_t cfg_q;

	// Register write decode; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_decrypt <= 1'b0;
			cfg_q.key_count    <= kbc_pkg::CNT_W'(1);
			cfg_q.keys         <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				kbc_pkg::REG_MODE_DECRYPT: cfg_q.mode_decrypt <= wr_data[0];
				kbc_pkg::REG_KEY_COUNT:    cfg_q.key_count <= wr_data[kbc_pkg::CNT_W-1:0];
				kbc_pkg::REG_KEY_ZERO:     cfg_q.keys[0] <= wr_data;
				kbc_pkg::REG_KEY_ONE:      cfg_q.keys[1] <= wr_data;
				kbc_pkg::REG_KEY_TWO:      cfg_q.keys[2] <= wr_data;
				kbc_pkg::REG_KEY_THREE:    cfg_q.keys[3] <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/kbc_key_seq.sv
// Key sequencer: bit position and key ring slot, picks key and step kind.
// Depends on kbc_pkg for the config and step structs.
`default_nettype none

module kbc_key_seq #(
	parameter int NUM_KEYS = kbc_pkg::NUM_KEYS_DEF,
	parameter int KEY_BITS = kbc_pkg::KEY_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire kbc_pkg::kbc_cfg_t    cfg,
	output kbc_pkg::kbc_step_t        step
);

	localparam int POS_W     = $clog2(KEY_BITS);
	localparam int LOW_START = KEY_BITS - 8;   // first position reading key bit 7
	localparam int ACT_MAX   = (NUM_KEYS < kbc_pkg::KEY_REGS) ? NUM_KEYS : kbc_pkg::KEY_REGS;

	logic [POS_W-1:0]           bit_position_q;
	logic [kbc_pkg::SLOT_W-1:0] key_slot_q;
	logic [7:0]                 key;
	logic [2:0]                 tail_idx;
	logic                       key_bit;
	logic                       last_pos;
	logic [kbc_pkg::CNT_W-1:0]  act_count;
	logic [kbc_pkg::CNT_W-1:0]  slot_next;

	// Current key and its bit; positions before LOW_START read as zero
	assign key      = cfg.keys[key_slot_q];
	assign tail_idx = 3'(bit_position_q - POS_W'(LOW_START));
	assign key_bit  = (bit_position_q >= POS_W'(LOW_START)) ? key[3'd7 - tail_idx] : 1'b0;

	assign step.key      = key;
	assign step.add_step = key_bit ^ bit_position_q[0];
	assign step.decrypt  = cfg.mode_decrypt;

	// Effective ring length: zero acts as one, clamp to what exists
	always_comb begin
		act_count = cfg.key_count;
		if (act_count == '0)
			act_count = kbc_pkg::CNT_W'(1);
		if (act_count > kbc_pkg::CNT_W'(ACT_MAX))
			act_count = kbc_pkg::CNT_W'(ACT_MAX);
	end

	assign last_pos  = (bit_position_q == POS_W'(KEY_BITS - 1));
	assign slot_next = {1'b0, key_slot_q} + kbc_pkg::CNT_W'(1);

	// Position counter and key ring walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_position_q <= '0;
			key_slot_q     <= '0;
		end else if (advance) begin
			if (last_pos) begin
				bit_position_q <= '0;
				if (slot_next >= act_count)
					key_slot_q <= '0;
				else
					key_slot_q <= slot_next[kbc_pkg::SLOT_W-1:0];
			end else begin
				bit_position_q <= bit_position_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/kbc_crypt.sv
// Byte transform: signed add or subtract of the key with wrap by 254.
// Depends on kbc_pkg for byte codes, limits and the step struct.
`default_nettype none

module kbc_crypt (
	input  wire logic [7:0]          data_in,
	input  wire kbc_pkg::kbc_step_t  step,
	output logic [7:0]               data_out
);

	logic signed [9:0] x;
	logic signed [9:0] k;
	logic signed [9:0] sum;
	logic signed [9:0] diff;
	logic signed [9:0] w;

	assign x    = $signed({{2{data_in[7]}}, data_in});
	assign k    = $signed({2'b00, step.key});
	assign sum  = x + k;
	assign diff = x - k;

	// Encrypt uses inclusive wrap tests, decrypt the strict inverse
	always_comb begin
		w = x;
		if (data_in == kbc_pkg::BYTE_MIN) begin
			w = x;
		end else if (step.add_step) begin
			if (data_in != kbc_pkg::BYTE_MAX) begin
				if (!step.decrypt) begin
					w = (sum >= kbc_pkg::W_POS_LIM) ? sum - kbc_pkg::W_WRAP : sum;
				end else begin
					w = (diff < kbc_pkg::W_NEG_LIM) ? diff + kbc_pkg::W_WRAP : diff;
				end
			end
		end else begin
			if (data_in != kbc_pkg::BYTE_NEG_MAX) begin
				if (!step.decrypt) begin
					w = (diff <= kbc_pkg::W_NEG_LIM) ? diff + kbc_pkg::W_WRAP : diff;
				end else begin
					w = (sum > kbc_pkg::W_POS_LIM) ? sum - kbc_pkg::W_WRAP : sum;
				end
			end
		end
	end

	assign data_out = w[7:0];

endmodule

`default_nettype wire

// File: hw/rtl/keyed_byte_add_sub_cipher.sv
// Keyed byte add/sub cipher, top level.
// A transferred byte is held in the input register, then in the result register that drives out_byte.
// Throughput: one byte per cycle unless out_stall holds the result register.
// Reset (arst_n low, async): both pipeline stages empty, position and key
// slot zero, mode encrypt, key_count one, all keys zero.
`default_nettype none
`include "assert_macros.svh"

module keyed_byte_add_sub_cipher #(
	parameter int NUM_KEYS = kbc_pkg::NUM_KEYS_DEF,
	parameter int KEY_BITS = kbc_pkg::KEY_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// byte input
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 data_byte,
	// byte output
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      out_byte,
	// configuration writes
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [kbc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                 cfg_data
);

	kbc_pkg::kbc_cfg_t  cfg;
	kbc_pkg::kbc_step_t step;
	kbc_pkg::kbc_step_t step_s1;
	logic [7:0]         data_s1;
	logic               valid_s1;
	logic [7:0]         result;
	logic [7:0]         out_byte_s2;
	logic               valid_s2;
	logic               load_s2;
	logic               in_xfer;

	assign cfg_ready = 1'b1;

	kbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kbc_key_seq #(
		.NUM_KEYS (NUM_KEYS),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_xfer),
		.cfg     (cfg),
		.step    (step)
	);

	// Stage handshake: result register frees when empty or taken
	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign in_xfer  = in_valid && !in_stall;

	// Input register: byte plus its step selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= data_byte;
			step_s1 <= step;
		end
	end

	kbc_crypt u_crypt (
		.data_in  (data_s1),
		.step     (step_s1),
		.data_out (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1)
			out_byte_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_byte  = out_byte_s2;

	// Checks
	`KBC_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !load_s2, valid_s1, "s1 item dropped while blocked")
	`KBC_ASSERT(a_stall_needs_s1, clk, arst_n, !in_stall || valid_s1, "input stalled with s1 empty")
	`KBC_ASSERT(a_out_from_s1, clk, arst_n, !$rose(valid_s2) || $past(valid_s1), "result without s1 item")

endmodule

`default_nettype wire
